### rtl/pflm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pflm_pkg
// Shared types and constants of the page frame list manager.
// ----------------------------------------------------------------------------
package pflm_pkg;

    localparam int PAGE_COUNT_DEF = 1024;
    localparam int LIST_COUNT     = 4;
    localparam int LIST_IDX_W     = $clog2(LIST_COUNT);
    localparam int PAGE_W         = 10;
    localparam int LOC_W          = 3;

    typedef logic [LOC_W-1:0] t_loc;

    localparam t_loc LOC_ZEROED     = 3'd0;
    localparam t_loc LOC_FREE       = 3'd1;
    localparam t_loc LOC_MODIFIED   = 3'd2;
    localparam t_loc LOC_STANDBY    = 3'd3;
    localparam t_loc LOC_ACTIVE     = 3'd4;
    localparam t_loc LOC_TRANSITION = 3'd5;
    localparam t_loc LOC_RESERVED   = 3'd6;
    localparam t_loc LOC_ILLEGAL    = 3'd7;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_UNLINK,
        S_LINK,
        S_FINISH,
        S_HOLD
    } t_state;

    // Locations below LIST_COUNT are linked lists.
    function automatic logic is_list(input t_loc loc);
        return loc < t_loc'(LIST_COUNT);
    endfunction

endpackage : pflm_pkg
`default_nettype wire

### rtl/pflm_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pflm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pflm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule : pflm_ram
`default_nettype wire

### rtl/page_frame_list_manager_unit.sv
`default_nettype none
// Sequence: a move passes S_UNLINK, S_LINK and S_FINISH, a rejected or out-of-range
//   request S_UNLINK alone, then waits in S_HOLD while the result register is full.
//   A request waits for the last result to be loaded. The three write passes over
//   the shared next/prev link memories after the one read set a move's pace.
// Reset: synchronous, active low; lists empty, then a clearing pass over all pages
//   marks every page reserved before the first request is taken.
// ----------------------------------------------------------------------------
// page_frame_list_manager_unit
// Page frame database: per-page location code plus doubly linked lists for the
// zeroed, free, modified and standby locations, with one head per list.
// ----------------------------------------------------------------------------
module page_frame_list_manager_unit
    import pflm_pkg::*;
#(
    parameter int PAGE_COUNT = PAGE_COUNT_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // request channel
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [PAGE_W-1:0] i_page_index,
    input  wire logic [LOC_W-1:0]  i_new_location,
    // result channel
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic      [LOC_W-1:0]  o_previous_location,
    output logic                   o_rejected,
    output logic                   o_dest_head_valid,
    output logic      [PAGE_W-1:0] o_dest_head
);

    // page address width, link = {null flag, page address}
    localparam int AW   = $clog2(PAGE_COUNT);
    localparam int LW   = AW + 1;
    localparam int NX_W = LOC_W + LW;

    localparam logic [LW-1:0] NULL_LINK = {1'b1, {AW{1'b0}}};

    // ------------------------------------------------------------------------
    // Memories
    //   next memory: {location, next link} per page. The location code rides
    //   with the next link: a neighbor being relinked sits on the same list as
    //   the moved page, so its code is known and the word is written whole.
    //   prev memory: prev link per page.
    // ------------------------------------------------------------------------
    logic              nx_we;
    logic [AW-1:0]     nx_waddr;
    logic [NX_W-1:0]   nx_wdata;
    logic [NX_W-1:0]   nx_rdata;
    logic              pv_we;
    logic [AW-1:0]     pv_waddr;
    logic [LW-1:0]     pv_wdata;
    logic [LW-1:0]     pv_rdata;
    logic [AW-1:0]     rd_addr;

    pflm_ram #(
        .WIDTH (NX_W),
        .DEPTH (PAGE_COUNT)
    ) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (nx_we),
        .i_waddr (nx_waddr),
        .i_wdata (nx_wdata),
        .i_raddr (rd_addr),
        .o_rdata (nx_rdata)
    );

    pflm_ram #(
        .WIDTH (LW),
        .DEPTH (PAGE_COUNT)
    ) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (pv_we),
        .i_waddr (pv_waddr),
        .i_wdata (pv_wdata),
        .i_raddr (rd_addr),
        .o_rdata (pv_rdata)
    );

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    t_state          r_state, n_state;
    logic [AW-1:0]   r_clr_addr;
    logic [LW-1:0]   r_head [LIST_COUNT];

    // request captured at accept
    logic [AW-1:0]   r_page;
    t_loc            r_nl;
    logic            r_pg_ok;

    // page record captured when the read returns
    t_loc            r_old;
    logic            r_rej;
    logic [LW-1:0]   r_prev;
    logic [LW-1:0]   r_next;
    logic [LW-1:0]   r_dhead;   // target list head before the push

    // output register
    logic            r_out_valid;
    t_loc            r_out_prev;
    logic            r_out_rej;
    logic            r_out_hv;
    logic [PAGE_W-1:0] r_out_head;

    // ------------------------------------------------------------------------
    // Decode of the returned record (valid in S_UNLINK only)
    // ------------------------------------------------------------------------
    t_loc            rd_loc;
    logic [LW-1:0]   rd_next;
    t_loc            w1_old;
    logic            w1_rej;
    logic            slot_free;
    logic            out_load;
    logic [LW-1:0]   nl_head;
    logic [LW-1:0]   old_head;

    assign rd_loc   = nx_rdata[NX_W-1 -: LOC_W];
    assign rd_next  = nx_rdata[LW-1:0];
    assign w1_old   = r_pg_ok ? rd_loc : LOC_RESERVED;
    // out-of-range page, or a move to where it already is: nothing changes
    assign w1_rej   = !r_pg_ok || (rd_loc == r_nl);
    assign nl_head  = r_head[r_nl[LIST_IDX_W-1:0]];
    assign old_head = r_head[r_old[LIST_IDX_W-1:0]];

    assign slot_free = !r_out_valid || i_out_ready;
    assign rd_addr   = AW'(i_page_index);

    // ------------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == AW'(PAGE_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_UNLINK;
                end
            end
            S_UNLINK: begin
                if (!w1_rej) begin
                    n_state = S_LINK;
                end else if (slot_free) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_HOLD;
                end
            end
            S_LINK: begin
                n_state = S_FINISH;
            end
            S_FINISH, S_HOLD: begin
                n_state = slot_free ? S_IDLE : S_HOLD;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Memory writes and handshake per state
    //   S_UNLINK: record of the page (new code, old head of target as next if a list);
    //             prev of the old next neighbor.
    //   S_LINK:   next of the old prev neighbor; prev of the target's old head.
    //   S_FINISH: prev of the page becomes null when it joined a list.
    // ------------------------------------------------------------------------
    always_comb begin
        nx_we      = 1'b0;
        nx_waddr   = r_page;
        nx_wdata   = {r_nl, nl_head};
        pv_we      = 1'b0;
        pv_waddr   = r_page;
        pv_wdata   = NULL_LINK;
        o_in_ready = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                nx_we    = 1'b1;
                nx_waddr = r_clr_addr;
                nx_wdata = {LOC_RESERVED, NULL_LINK};
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
            end
            S_UNLINK: begin
                if (!w1_rej) begin
                    nx_we    = 1'b1;
                    nx_wdata = {r_nl, is_list(r_nl) ? nl_head : rd_next};
                    if (is_list(rd_loc) && !rd_next[AW]) begin
                        pv_we    = 1'b1;
                        pv_waddr = rd_next[AW-1:0];
                        pv_wdata = pv_rdata;
                    end
                end else begin
                    out_load = slot_free;
                end
            end
            S_LINK: begin
                if (is_list(r_old) && !r_prev[AW]) begin
                    nx_we    = 1'b1;
                    nx_waddr = r_prev[AW-1:0];
                    nx_wdata = {r_old, r_next};
                end
                if (is_list(r_nl) && !r_dhead[AW]) begin
                    pv_we    = 1'b1;
                    pv_waddr = r_dhead[AW-1:0];
                    pv_wdata = {1'b0, r_page};
                end
            end
            S_FINISH: begin
                pv_we    = is_list(r_nl);
                out_load = slot_free;
            end
            S_HOLD: begin
                out_load = slot_free;
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Sequential logic
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < LIST_COUNT; i++) begin
                r_head[i] <= NULL_LINK;
            end
        end else begin
            r_state <= n_state;

            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end

            // head updates happen with the record read; old and new lists differ
            if (r_state == S_UNLINK && !w1_rej) begin
                if (is_list(rd_loc) && pv_rdata[AW]) begin
                    r_head[rd_loc[LIST_IDX_W-1:0]] <= rd_next;
                end
                if (is_list(r_nl)) begin
                    r_head[r_nl[LIST_IDX_W-1:0]] <= {1'b0, r_page};
                end
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_page  <= AW'(i_page_index);
            r_nl    <= (i_new_location == LOC_ILLEGAL) ? LOC_RESERVED : i_new_location;
            r_pg_ok <= 32'(i_page_index) < 32'(PAGE_COUNT);
        end
        if (r_state == S_UNLINK) begin
            r_old   <= w1_old;
            r_rej   <= w1_rej;
            r_prev  <= pv_rdata;
            r_next  <= rd_next;
            r_dhead <= nl_head;
        end
        if (out_load) begin
            r_out_prev <= (r_state == S_UNLINK) ? w1_old : r_old;
            r_out_rej  <= (r_state == S_UNLINK) ? 1'b1 : r_rej;
            r_out_hv   <= is_list(r_nl) && !nl_head[AW];
            r_out_head <= (is_list(r_nl) && !nl_head[AW]) ? PAGE_W'(nl_head[AW-1:0])
                                                          : '0;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_previous_location = r_out_prev;
    assign o_rejected          = r_out_rej;
    assign o_dest_head_valid   = r_out_hv;
    assign o_dest_head         = r_out_head;

`ifndef NO_ASSERTIONS
    // the memories are idle while waiting for a request
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!nx_we && !pv_we))
        else $error("memory write while idle");

    // a successful push leaves the page at the head of its target list
    a_push_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UNLINK && !w1_rej && is_list(r_nl))
            |=> (r_head[r_nl[LIST_IDX_W-1:0]] == {1'b0, r_page}))
        else $error("target head is not the moved page");

    // after unlinking, the old list no longer starts at the moved page
    a_old_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LINK && is_list(r_old)) |-> (old_head != {1'b0, r_page}))
        else $error("old list head still points at the moved page");

    // neighbor relink never targets the moved page itself
    a_neighbor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LINK && nx_we) |-> (nx_waddr != r_page))
        else $error("neighbor write hits the moved page");
`endif

endmodule : page_frame_list_manager_unit
`default_nettype wire
